// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, checked only while reset is released.
`define JKVE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define JKVE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JKVE_ASSERT(lbl, clk, rstn, prop, msg)
`define JKVE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/jkve_pkg.sv
// Shared types and character constants of the JSON key/value extractor.
package jkve_pkg;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       has_byte;
    logic       value_end;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACK) ||
           (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

// File: rtl/jkve_core.sv
// Per-byte parser: key window match, value phase tracking and result forming.
module jkve_core import jkve_pkg::*; #(
  parameter int KEY_MAX    = 16,
  parameter int DEPTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    msg_byte,
  input  logic          msg_last,
  input  logic [63:0]   key_low,
  input  logic [63:0]   key_high,
  input  logic [4:0]    key_len,
  output logic          res_valid,
  output result_t       res
);

  localparam int WIN    = KEY_MAX + 2;
  localparam int FILL_W = $clog2(WIN + 1);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_WANT_COLON,
    PH_WANT_VALUE,
    PH_BRACKET,
    PH_STRING,
    PH_SCALAR,
    PH_DONE
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [WIN-1:0][7:0]    win_r, win_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [DEPTH_BITS-1:0]  nest_r, nest_nxt;
  logic                   in_str_r, in_str_nxt;
  logic                   esc_r, esc_nxt;
  logic                   square_r, square_nxt;

  logic [15:0][7:0]       key_bytes;
  logic [4:0]             len;
  logic [5:0]             len_p1;
  logic [WIN-1:0][7:0]    expect_b;
  logic [WIN-1:0]         care;
  logic                   match;
  logic                   emit;
  logic [7:0]             c;
  logic [7:0]             open_ch;
  logic [7:0]             close_ch;
  logic [DEPTH_BITS-1:0]  nest_dec;

  assign c         = msg_byte;
  assign key_bytes = {key_high, key_low};
  assign len       = (key_len > 5'(KEY_MAX)) ? 5'(KEY_MAX) : key_len;
  assign len_p1    = {1'b0, len} + 6'd1;

  // Expected window contents, most recent byte first: quote, key reversed, quote.
  always_comb begin
    logic [4:0] idx;
    for (int j = 0; j < WIN; j++) begin
      idx = len - 5'(j);
      care[j] = (6'(j) <= len_p1);
      if (j == 0 || 6'(j) == len_p1) begin
        expect_b[j] = CH_QUOTE;
      end else begin
        expect_b[j] = key_bytes[idx[3:0]];
      end
    end
  end

  always_comb begin
    win_nxt[0] = c;
    for (int k = 1; k < WIN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_comb begin
    match = (6'(fill_nxt) >= len_p1 + 6'd1);
    for (int j = 0; j < WIN; j++) begin
      if (care[j] && (win_nxt[j] != expect_b[j])) begin
        match = 1'b0;
      end
    end
  end

  assign open_ch  = square_r ? CH_LBRACK : CH_LBRACE;
  assign close_ch = square_r ? CH_RBRACK : CH_RBRACE;
  assign nest_dec = nest_r - {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  assign fill_nxt = (fill_r < FILL_W'(WIN)) ? fill_r + {{(FILL_W-1){1'b0}}, 1'b1} : fill_r;

  always_comb begin
    phase_nxt  = phase_r;
    nest_nxt   = nest_r;
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    square_nxt = square_r;
    emit       = 1'b0;
    case (phase_r)
      PH_SEARCH: begin
        if (match) begin
          phase_nxt = PH_WANT_COLON;
        end
      end
      PH_WANT_COLON: begin
        if (c == CH_COLON) begin
          phase_nxt = PH_WANT_VALUE;
        end else if (!(is_blank(c) || c == CH_CR || c == CH_LF)) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_WANT_VALUE: begin
        if (is_blank(c)) begin
          phase_nxt = PH_WANT_VALUE;
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
          square_nxt = (c == CH_LBRACK);
          nest_nxt   = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
          in_str_nxt = 1'b0;
          esc_nxt    = 1'b0;
          phase_nxt  = PH_BRACKET;
          emit       = 1'b1;
        end else if (c == CH_QUOTE) begin
          esc_nxt   = 1'b0;
          phase_nxt = PH_STRING;
          emit      = 1'b1;
        end else if (is_delim(c)) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_SCALAR;
          emit      = 1'b1;
        end
      end
      PH_BRACKET: begin
        emit = 1'b1;
        if (in_str_r) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (c == CH_QUOTE) begin
            in_str_nxt = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          in_str_nxt = 1'b1;
        end else if (c == open_ch) begin
          // saturate at the top of the counter
          if (nest_r != '1) begin
            nest_nxt = nest_r + {{(DEPTH_BITS-1){1'b0}}, 1'b1};
          end
        end else if (c == close_ch) begin
          nest_nxt = nest_dec;
          if (nest_dec == '0) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_STRING: begin
        emit = 1'b1;
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (c == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (c == CH_QUOTE) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SCALAR: begin
        if (is_delim(c)) begin
          phase_nxt = PH_DONE;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign res_valid      = in_fire && (emit || msg_last);
  assign res.value_byte = emit ? c : 8'h00;
  assign res.has_byte   = emit;
  assign res.value_end  = msg_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      fill_r   <= '0;
      nest_r   <= '0;
      in_str_r <= 1'b0;
      esc_r    <= 1'b0;
      square_r <= 1'b0;
    end else if (in_fire) begin
      if (msg_last) begin
        // restart for the next message
        phase_r  <= PH_SEARCH;
        fill_r   <= '0;
        nest_r   <= '0;
        in_str_r <= 1'b0;
        esc_r    <= 1'b0;
        square_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        nest_r   <= nest_nxt;
        in_str_r <= in_str_nxt;
        esc_r    <= esc_nxt;
        square_r <= square_nxt;
        if (phase_r == PH_SEARCH) begin
          fill_r <= fill_nxt;
        end
      end
    end
  end

  // Window contents beyond the fill count are never compared.
  always_ff @(posedge clk) begin
    if (in_fire && !msg_last && phase_r == PH_SEARCH) begin
      win_r <= win_nxt;
    end
  end

endmodule

// File: rtl/jkve_skid.sv
// Output beat register with one skid entry.
module jkve_skid import jkve_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= in_valid;
      end else begin
        out_valid_r <= in_valid;
      end
    end else if (in_valid) begin
      // hold the new beat while the output is stalled
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= in_data;
      end else begin
        out_data_r <= in_data;
      end
    end else if (in_valid) begin
      skid_data_r <= in_data;
    end
  end

endmodule

// File: rtl/json_key_value_extractor.sv
// Streaming JSON key/value extractor: one message byte per beat in, raw value
// bytes out. One byte is accepted every cycle while in_tready is high; each
// beat is parsed in the cycle it is accepted. Its result, if any, goes into the
// output register or, on an output stall, into the single skid entry behind it,
// so the input keeps flowing for one extra beat; in_tready drops only when both
// the output register and the skid entry hold data. Value bytes carry out_tuser
// high; the last byte of each message always yields exactly one beat with
// out_tlast high, with out_tuser low and out_tdata zero if that byte was not
// part of the value. The key is matched on its first raw quoted occurrence.
module json_key_value_extractor import jkve_pkg::*; #(
  parameter int KEY_MAX    = 16,
  parameter int DEPTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] value_byte
  output logic [0:0]  out_tuser,  // [0] has_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

`include "assert_macros.svh"

  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic [4:0]  key_len_r;
  logic        in_fire;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata;
        REG_KEY_LEN:  key_len_r  <= cfg_wdata[4:0];
        default:      key_len_r  <= key_len_r;
      endcase
    end
  end

  jkve_core #(
    .KEY_MAX    (KEY_MAX),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .msg_byte  (in_tdata),
    .msg_last  (in_tlast),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .key_len   (key_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  jkve_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res.value_byte;
  assign out_tuser = out_res.has_byte;
  assign out_tlast = out_res.value_end;

  `JKVE_ASSERT(a_skid_implies_out, clk, rst_n, !in_tready |-> out_tvalid, "skid full with empty output")
  `JKVE_ASSERT(a_ready_fall, clk, rst_n, $fell(in_tready) |-> $past(out_tvalid && !out_tready), "ready fell without stall")
  `JKVE_ASSERT(a_last_gives_beat, clk, rst_n, (in_fire && in_tlast) |=> out_tvalid, "message end lost")
  `JKVE_ASSERT(a_empty_beat_is_end, clk, rst_n, (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata == 8'h00), "empty beat not a clean end")

endmodule
